FILE: rtl/assert_macros.svh
// Assertion macros shared by the RTL of the queue block.
// Depends on a clock named i_clk and an active-low reset named i_rst_n in the using module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: rtl/fqms_pkg.sv
// Package of the FIFO queue with membership search: item types, codes and default depth.
// Depends on nothing; used by the top level.
package fqms_pkg;

    localparam int QUEUE_DEPTH = 64;
    localparam int DATA_W      = 32;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        REQ_PUSH   = 2'd0,
        REQ_POP    = 2'd1,
        REQ_SEARCH = 2'd2,
        REQ_NOP    = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_POP_FILL,
        S_SCAN,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic [1:0]               req_type;
        logic signed [DATA_W-1:0] data_value;
    } t_in_item;

    typedef struct packed {
        logic signed [DATA_W-1:0] out_value;
        logic                     found;
        logic                     is_empty_flag;
        logic [CNT_W-1:0]         entry_count;
        logic [1:0]               status;
    } t_out_item;

endpackage

FILE: rtl/fifo_queue_with_membership_search_unit.sv
// Sequence: push, failed pop, no-op and empty-queue search items go from S_IDLE straight to
// S_EMIT; a successful pop passes through S_POP_FILL, a search through S_SCAN. S_EMIT loads
// the output register once it is free. Only one item is in flight; o_in_stall holds the input
// outside S_IDLE, and the next item is taken the cycle after a result loads.
// Reset (synchronous, active low) clears head, count, sequencer state and output valid only.
// File holds the top level; depends on fqms_pkg and assert_macros.svh.
`include "assert_macros.svh"

module fifo_queue_with_membership_search_unit
    import fqms_pkg::*;
#(
    parameter int P_DEPTH = QUEUE_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    // Address width of the ring and width of the live count (which must hold P_DEPTH itself).
    localparam int AW = $clog2(P_DEPTH);
    localparam int CW = $clog2(P_DEPTH + 1);
    localparam logic [CW:0]   DEPTH_SUM = (CW + 1)'(P_DEPTH);
    localparam logic [CW-1:0] DEPTH_CNT = CW'(P_DEPTH);
    localparam logic [AW-1:0] LAST_SLOT = AW'(P_DEPTH - 1);

    // The entries live in a single synchronous memory with one write and one read port.
    // The memory is not cleared, since only written entries are ever compared or reported.
    logic [DATA_W-1:0] r_mem [P_DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    // Sequencer state. The front value is cached in r_front so that every result can
    // report it without a memory read; a pop refreshes it from the memory.
    t_state            r_state, n_state;
    logic [AW-1:0]     r_head, n_head;
    logic [CW-1:0]     r_count, n_count;
    logic [DATA_W-1:0] r_front, n_front;
    logic [DATA_W-1:0] r_key, n_key;
    logic [AW-1:0]     r_ptr, n_ptr;
    logic [CW-1:0]     r_idx, n_idx;
    t_out_item         r_res, n_res;
    t_out_item         r_out;
    logic              r_out_valid;

    logic              w_accept;
    logic              w_out_free;
    logic              w_load;
    logic              w_wr_en;
    logic [AW-1:0]     w_wr_addr;
    logic [AW-1:0]     w_rd_addr;
    logic [CW:0]       w_tail_sum;
    logic [AW-1:0]     w_tail;
    t_req              w_req;

    function automatic logic [AW-1:0] f_next_slot(input logic [AW-1:0] slot);
        return (slot == LAST_SLOT) ? '0 : slot + AW'(1);
    endfunction

    assign o_in_stall  = (r_state != S_IDLE);
    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;
    assign w_req       = t_req'(i_in_item.req_type);

    // The tail slot is head plus count, wrapped once; the sum stays below twice the depth.
    assign w_tail_sum = (CW + 1)'(r_head) + (CW + 1)'(r_count);
    assign w_tail     = (w_tail_sum >= DEPTH_SUM) ? AW'(w_tail_sum - DEPTH_SUM)
                                                  : AW'(w_tail_sum);

    // Next-state logic of the sequencer.
    always_comb begin
        n_state   = r_state;
        n_head    = r_head;
        n_count   = r_count;
        n_front   = r_front;
        n_key     = r_key;
        n_ptr     = r_ptr;
        n_idx     = r_idx;
        n_res     = r_res;
        w_wr_en   = 1'b0;
        w_wr_addr = w_tail;
        w_rd_addr = r_ptr;
        w_load    = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_res.found  = 1'b0;
                    n_res.status = ST_OK;
                    n_res.out_value = (r_count == '0) ? '0 : $signed(r_front);
                    n_state = S_EMIT;
                    unique case (w_req)
                        REQ_PUSH: begin
                            if (r_count == DEPTH_CNT) begin
                                n_res.status = ST_FULL;
                            end else begin
                                w_wr_en = 1'b1;
                                n_count = r_count + CW'(1);
                                if (r_count == '0) begin
                                    n_front         = i_in_item.data_value;
                                    n_res.out_value = i_in_item.data_value;
                                end
                            end
                        end
                        REQ_POP: begin
                            if (r_count == '0) begin
                                n_res.status = ST_EMPTY;
                            end else begin
                                // Fetch the new front entry; it is in r_rd_data in S_POP_FILL.
                                n_head    = f_next_slot(r_head);
                                n_count   = r_count - CW'(1);
                                w_rd_addr = f_next_slot(r_head);
                                n_state   = S_POP_FILL;
                            end
                        end
                        REQ_SEARCH: begin
                            if (r_count != '0) begin
                                // Start the walk at the head; one entry is compared per cycle.
                                n_key     = i_in_item.data_value;
                                w_rd_addr = r_head;
                                n_ptr     = f_next_slot(r_head);
                                n_idx     = CW'(1);
                                n_state   = S_SCAN;
                            end
                        end
                        REQ_NOP: begin
                        end
                    endcase
                    n_res.entry_count   = CNT_W'(n_count);
                    n_res.is_empty_flag = (n_count == '0);
                end
            end
            S_POP_FILL: begin
                n_front = r_rd_data;
                n_state = S_EMIT;
            end
            S_SCAN: begin
                // r_rd_data holds the entry at offset r_idx - 1 from the head.
                if (r_rd_data == r_key) begin
                    n_res.found = 1'b1;
                    n_state     = S_EMIT;
                end else if (r_idx == r_count) begin
                    n_state = S_EMIT;
                end else begin
                    w_rd_addr = r_ptr;
                    n_ptr     = f_next_slot(r_ptr);
                    n_idx     = r_idx + CW'(1);
                end
            end
            S_EMIT: begin
                if (w_out_free) begin
                    w_load  = 1'b1;
                    n_state = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= i_in_item.data_value;
        end
        r_rd_data <= r_mem[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_count <= n_count;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_front <= n_front;
        r_key   <= n_key;
        r_ptr   <= n_ptr;
        r_idx   <= n_idx;
        r_res   <= n_res;
        if (w_load) begin
            r_out <= r_res;
        end
    end

    `ASSERT_IMPLIES(a_count_range, 1'b1, r_count <= DEPTH_CNT)
    `ASSERT_IMPLIES(a_scan_bounds, r_state == S_SCAN, (r_count != '0) && (r_idx <= r_count))
    `ASSERT_NEXT(a_pop_refill, w_accept && (w_req == REQ_POP) && (r_count != '0),
                 r_state == S_POP_FILL)
    `ASSERT_IMPLIES(a_load_from_emit, $rose(r_out_valid), $past(r_state) == S_EMIT)

endmodule
